// File: hw/rtl/distance_vector_route_table_core_macros.svh
// assertion macros for the route table core
// both rely on clk_i and rst_ni in the module that uses them
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_CORE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define DVRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define DVRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define DVRT_ASSERT(lbl, prop, msg)
`define DVRT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/dvrt_pkg.sv
package dvrt_pkg;

  localparam int TableEntries = 16;
  localparam int NodeIdBits   = 8;
  localparam int CostBits     = 16;
  localparam int IdxBits      = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntBits      = IdxBits + 1;

  localparam logic FuncRelax = 1'b0;
  localparam logic FuncSet   = 1'b1;

  localparam logic [CostBits-1:0] CostMax = {CostBits{1'b1}};

  typedef struct packed {
    logic                  func;
    logic [NodeIdBits-1:0] neighbor_id;
    logic [CostBits-1:0]   link_cost;
    logic [NodeIdBits-1:0] dest_id;
    logic [CostBits-1:0]   advertised_cost;
  } dvrt_in_t;

  typedef struct packed {
    logic [NodeIdBits-1:0] route_dest;
    logic [CostBits-1:0]   route_cost;
    logic [NodeIdBits-1:0] route_next_hop;
    logic                  changed;
    logic                  table_full;
  } dvrt_out_t;

  // one table row as stored in the ram
  typedef struct packed {
    logic [NodeIdBits-1:0] dest;
    logic [CostBits-1:0]   cost;
    logic [NodeIdBits-1:0] next_hop;
  } dvrt_entry_t;

  typedef struct packed {
    logic                  start;
    logic                  func;
    logic [NodeIdBits-1:0] neighbor_id;
    logic [NodeIdBits-1:0] dest_id;
    logic [CostBits-1:0]   cand_cost;
    logic [NodeIdBits-1:0] self_id;
  } dvrt_req_t;

  typedef struct packed {
    logic      done;
    dvrt_out_t result;
  } dvrt_resp_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_DONE  = 3'b100
  } scan_state_e;

endpackage

// File: hw/rtl/dvrt_ram.sv
module dvrt_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/dvrt_scan.sv
`include "distance_vector_route_table_core_macros.svh"

module dvrt_scan import dvrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dvrt_req_t  req_i,
  input  logic       ack_i,
  output dvrt_resp_t resp_o
);

  scan_state_e state_q, state_d;
  logic [IdxBits-1:0] idx_q, idx_d;
  logic [CntBits-1:0] fill_q, fill_d;
  dvrt_out_t res_q, res_d;

  logic               ram_we;
  logic [IdxBits-1:0] ram_waddr;
  dvrt_entry_t        ram_wdata;
  logic               ram_re;
  logic [IdxBits-1:0] ram_raddr;
  dvrt_entry_t        ram_rdata;

  logic miss;
  logic last;
  logic better;

  dvrt_ram #(
    .Width($bits(dvrt_entry_t)),
    .Depth(TableEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign last   = ({1'b0, idx_q} + CntBits'(1)) >= fill_q;
  assign better = (req_i.func == FuncSet) || (req_i.cand_cost < ram_rdata.cost);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    fill_d    = fill_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '{dest: req_i.dest_id, cost: req_i.cand_cost, next_hop: req_i.neighbor_id};
    ram_re    = 1'b0;
    ram_raddr = '0;
    miss      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          res_d.route_dest = req_i.dest_id;
          res_d.changed    = 1'b0;
          res_d.table_full = 1'b0;
          if (req_i.dest_id == req_i.self_id) begin
            // own destination never touches the table
            res_d.route_cost     = '0;
            res_d.route_next_hop = req_i.self_id;
            state_d              = S_DONE;
          end else if (fill_q == '0) begin
            miss = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            idx_d     = '0;
            state_d   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (ram_rdata.dest == req_i.dest_id) begin
          ram_we               = better;
          res_d.changed        = better;
          res_d.route_cost     = better ? req_i.cand_cost : ram_rdata.cost;
          res_d.route_next_hop = better ? req_i.neighbor_id : ram_rdata.next_hop;
          state_d              = S_DONE;
        end else if (!last) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + IdxBits'(1);
          idx_d     = idx_q + IdxBits'(1);
        end else begin
          miss = 1'b1;
        end
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // unknown destination: append at the fill point or report full
    if (miss) begin
      state_d = S_DONE;
      if (fill_q < CntBits'(TableEntries)) begin
        ram_we               = 1'b1;
        ram_waddr            = fill_q[IdxBits-1:0];
        fill_d               = fill_q + CntBits'(1);
        res_d.changed        = 1'b1;
        res_d.route_cost     = req_i.cand_cost;
        res_d.route_next_hop = req_i.neighbor_id;
      end else begin
        res_d.table_full     = 1'b1;
        res_d.route_cost     = '0;
        res_d.route_next_hop = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign resp_o.done   = (state_q == S_DONE);
  assign resp_o.result = res_q;

  `DVRT_ASSERT(a_fill_bound, fill_q <= CntBits'(TableEntries), "fill count beyond table size")
  `DVRT_ASSERT_IMPL(a_scan_in_range, state_q == S_CHECK, ({1'b0, idx_q} < fill_q),
                    "scan index past filled rows")
  `DVRT_ASSERT_IMPL(a_fill_step, fill_q != $past(fill_q),
                    fill_q == CntBits'($past(fill_q) + CntBits'(1)), "fill count jumped")
  `DVRT_ASSERT_IMPL(a_write_when_deciding, ram_we, state_q == S_CHECK || state_q == S_IDLE,
                    "table write outside a decision cycle")

endmodule

// File: hw/rtl/distance_vector_route_table_core.sv
// route table core: one result beat per accepted input beat
// the own destination and an empty table skip the scan; else rows are scanned one a cycle
// until the destination is found or the filled rows run out
// one item in flight: the next is accepted once the result is registered at the output
// reset: asynchronous active low, clears the fill count (table empty) and self id to 0
module distance_vector_route_table_core import dvrt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dvrt_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output dvrt_out_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [NodeIdBits-1:0] cfg_data_i
);

  logic                  busy_q;
  logic                  start_q;
  logic                  out_valid_q;
  dvrt_out_t             out_q;
  logic [NodeIdBits-1:0] self_id_q;
  logic                  func_q;
  logic [NodeIdBits-1:0] nbr_q;
  logic [NodeIdBits-1:0] dest_q;
  logic [CostBits-1:0]   cand_q;

  logic                in_accept;
  logic                out_free;
  logic [CostBits:0]   sum;
  logic [CostBits-1:0] cand;
  dvrt_req_t           req;
  dvrt_resp_t          resp;

  assign in_ready_o  = !busy_q;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  // candidate cost: link cost for a set, else the sum saturated on carry out
  assign sum  = {1'b0, in_data_i.link_cost} + {1'b0, in_data_i.advertised_cost};
  assign cand = (in_data_i.func == FuncSet) ? in_data_i.link_cost :
                (sum[CostBits] ? CostMax : sum[CostBits-1:0]);

  assign req = '{start: start_q, func: func_q, neighbor_id: nbr_q, dest_id: dest_q,
                 cand_cost: cand_q, self_id: self_id_q};

  dvrt_scan u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .ack_i (out_free),
    .resp_o(resp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      self_id_q   <= '0;
    end else begin
      start_q <= in_accept;
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (resp.done && out_free) begin
        busy_q <= 1'b0;
      end
      if (resp.done && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        self_id_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= in_data_i.func;
      nbr_q  <= in_data_i.neighbor_id;
      dest_q <= in_data_i.dest_id;
      cand_q <= cand;
    end
    if (resp.done && out_free) begin
      out_q <= resp.result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb import dvrt_pkg::*; ();

  // tracks the route table and the route beats it has yet to answer
  class route_scoreboard;
    logic [NodeIdBits-1:0] self_id;
    logic                  row_valid[TableEntries];
    logic [NodeIdBits-1:0] row_dest[TableEntries];
    logic [CostBits-1:0]   row_cost[TableEntries];
    logic [NodeIdBits-1:0] row_hop[TableEntries];
    int                    rows_used;
    dvrt_out_t             expected_routes[$];
    int                    errors;
    int                    updates_seen;
    int                    changed_seen;
    int                    full_seen;
    int                    own_seen;

    function new();
      self_id   = '0;
      rows_used = 0;
      errors    = 0;
      updates_seen = 0;
      changed_seen = 0;
      full_seen    = 0;
      own_seen     = 0;
      for (int k = 0; k < TableEntries; k++) begin
        row_valid[k] = 1'b0;
        row_dest[k]  = '0;
        row_cost[k]  = '0;
        row_hop[k]   = '0;
      end
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return expected_routes.size();
    endfunction

    // works out the route beat an accepted update causes
    function void record_update(input dvrt_in_t beat);
      dvrt_out_t           res;
      logic [CostBits:0]   sum;
      logic [CostBits-1:0] cand;
      int                  slot;
      res = '0;
      res.route_dest = beat.dest_id;
      sum = {1'b0, beat.link_cost} + {1'b0, beat.advertised_cost};
      if (beat.func == FuncSet) begin
        cand = beat.link_cost;
      end else begin
        cand = sum[CostBits] ? CostMax : sum[CostBits-1:0];
      end
      if (beat.dest_id == self_id) begin
        res.route_next_hop = self_id;
        own_seen++;
      end else begin
        slot = -1;
        for (int k = 0; k < TableEntries; k++) begin
          if (slot < 0 && row_valid[k] && row_dest[k] == beat.dest_id) slot = k;
        end
        if (slot >= 0) begin
          if (beat.func == FuncSet || cand < row_cost[slot]) begin
            row_cost[slot] = cand;
            row_hop[slot]  = beat.neighbor_id;
            res.changed    = 1'b1;
          end
          res.route_cost     = row_cost[slot];
          res.route_next_hop = row_hop[slot];
        end else if (rows_used < TableEntries) begin
          row_valid[rows_used] = 1'b1;
          row_dest[rows_used]  = beat.dest_id;
          row_cost[rows_used]  = cand;
          row_hop[rows_used]   = beat.neighbor_id;
          rows_used++;
          res.changed        = 1'b1;
          res.route_cost     = cand;
          res.route_next_hop = beat.neighbor_id;
        end else begin
          res.table_full = 1'b1;
          full_seen++;
        end
      end
      if (res.changed) changed_seen++;
      updates_seen++;
      expected_routes = {expected_routes, res};
    endfunction

    task check_route(input dvrt_out_t got);
      dvrt_out_t want;
      if (expected_routes.size() == 0) begin
        report($sformatf("route beat with nothing outstanding, dest %0d", got.route_dest));
      end else begin
        want = expected_routes.pop_front();
        if (got.route_dest !== want.route_dest)
          report($sformatf("route_dest %0d, want %0d", got.route_dest, want.route_dest));
        if (got.route_cost !== want.route_cost)
          report($sformatf("dest %0d route_cost %0d, want %0d", want.route_dest,
                           got.route_cost, want.route_cost));
        if (got.route_next_hop !== want.route_next_hop)
          report($sformatf("dest %0d route_next_hop %0d, want %0d", want.route_dest,
                           got.route_next_hop, want.route_next_hop));
        if (got.changed !== want.changed)
          report($sformatf("dest %0d changed %0b, want %0b", want.route_dest,
                           got.changed, want.changed));
        if (got.table_full !== want.table_full)
          report($sformatf("dest %0d table_full %0b, want %0b", want.route_dest,
                           got.table_full, want.table_full));
      end
    endtask
  endclass

  localparam int RandomPhases  = 5;
  localparam int PhaseItems    = 350;
  localparam int PoolSize      = 20;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  dvrt_in_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  dvrt_out_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [NodeIdBits-1:0] cfg_data_i = '0;

  route_scoreboard       sb = new();
  bit                    idle_on = 1'b1;
  logic [NodeIdBits-1:0] dest_pool[PoolSize];

  distance_vector_route_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d route beats outstanding", sb.pending());
    $display("[distance_vector_route_table_core] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.self_id = cfg_data_i;
      if (in_valid_i && in_ready_o) sb.record_update(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_route(out_data_o);
    end
  end

  // receiver with random stall bursts
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic dvrt_in_t make_update(input logic f, input logic [NodeIdBits-1:0] nbr,
                                           input logic [CostBits-1:0] link,
                                           input logic [NodeIdBits-1:0] dest,
                                           input logic [CostBits-1:0] adv);
    dvrt_in_t beat;
    beat.func            = f;
    beat.neighbor_id     = nbr;
    beat.link_cost       = link;
    beat.dest_id         = dest;
    beat.advertised_cost = adv;
    return beat;
  endfunction

  function automatic logic [CostBits-1:0] pick_cost();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CostMax;
      2, 3:    return CostBits'($urandom);
      default: return CostBits'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic dvrt_in_t random_update();
    int                    pick;
    logic [NodeIdBits-1:0] dest;
    pick = $urandom_range(0, 99);
    if (pick < 8) dest = sb.self_id;
    else if (pick < 20) dest = NodeIdBits'($urandom);
    else dest = dest_pool[$urandom_range(0, PoolSize - 1)];
    return make_update(($urandom_range(0, 9) < 3) ? FuncSet : FuncRelax,
                       NodeIdBits'($urandom), pick_cost(), dest, pick_cost());
  endfunction

  task automatic send_update(input dvrt_in_t beat);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic write_self_id(input logic [NodeIdBits-1:0] id);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= id;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one edge first so a beat accepted at the current edge is already counted
  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    dvrt_in_t              directed[$];
    logic [NodeIdBits-1:0] phase_ids[RandomPhases];

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_self_id(8'd0);

    // equal cost keeps the stored route, a direct set always writes
    directed = {directed, make_update(FuncRelax, 8'hFF, 16'd0, 8'd1, 16'd0)};
    directed = {directed, make_update(FuncRelax, 8'h11, 16'd0, 8'd1, 16'd0)};
    directed = {directed, make_update(FuncSet, 8'd0, CostMax, 8'd1, 16'h1234)};
    directed = {directed, make_update(FuncRelax, 8'h22, CostMax, 8'd1, CostMax)};
    directed = {directed, make_update(FuncRelax, 8'h33, 16'h8000, 8'd1, 16'h7FFE)};
    directed = {directed, make_update(FuncSet, 8'h33, 16'hFFFE, 8'd1, CostMax)};
    directed = {directed, make_update(FuncRelax, 8'h44, 16'd5, 8'd0, 16'd5)};
    directed = {directed, make_update(FuncSet, 8'hFF, CostMax, 8'd0, CostMax)};
    directed = {directed, make_update(FuncRelax, 8'hA5, CostMax, 8'hFF, 16'd0)};
    directed = {directed, make_update(FuncRelax, 8'h5A, 16'd1, 8'hFF, CostMax)};
    for (int k = 2; k < TableEntries; k++) begin
      directed = {directed, make_update(logic'(k[0]), NodeIdBits'(k * 17),
                                        CostBits'(k * 1000), NodeIdBits'(k), CostBits'(k))};
    end
    // table now holds every row, an unknown destination is dropped
    directed = {directed, make_update(FuncRelax, 8'h01, 16'd1, 8'h80, 16'd1)};

    foreach (directed[k]) begin
      send_update(directed[k]);
      sender_gap();
    end
    in_valid_i <= 1'b0;

    dest_pool[0] = 8'd1;
    dest_pool[1] = 8'hFF;
    for (int k = 2; k < TableEntries; k++) dest_pool[k] = NodeIdBits'(k);
    dest_pool[16] = 8'h80;
    dest_pool[17] = 8'h40;
    dest_pool[18] = 8'h2A;
    dest_pool[19] = 8'hD5;

    phase_ids[0] = 8'hFF;
    phase_ids[1] = 8'd5;
    phase_ids[2] = NodeIdBits'($urandom);
    phase_ids[3] = 8'd0;
    phase_ids[4] = 8'd12;

    for (int p = 0; p < RandomPhases; p++) begin
      wait_drained();
      write_self_id(phase_ids[p]);
      if (p == RandomPhases - 1) idle_on = 1'b0;
      for (int k = 0; k < PhaseItems; k++) begin
        send_update(random_update());
        sender_gap();
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d route beats never came", sb.pending()));

    $display("ran %0d updates over %0d self id settings, %0d routes changed",
             sb.updates_seen, RandomPhases + 1, sb.changed_seen);
    $display("%0d own-destination answers, %0d dropped on a full table, %0d mismatches",
             sb.own_seen, sb.full_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("[distance_vector_route_table_core] OK");
    end else begin
      $display("[distance_vector_route_table_core] ERROR");
    end
    $finish;
  end

endmodule
